FILE: rtl/tqps_pkg.sv
// ----------------------------------------------------------------------------
// tqps_pkg
// Types and constants shared by the two-queue policy scheduler.
// ----------------------------------------------------------------------------
package tqps_pkg;

    localparam int DefQueueDepth = 16;
    localparam int CmdFifoDepth  = 2;

    localparam logic       KIND_ENQ    = 1'b0;
    localparam logic       KIND_DEQ    = 1'b1;
    localparam logic [2:0] POL_FCFS    = 3'd0;
    localparam logic [2:0] POL_RR      = 3'd1;
    localparam logic [2:0] POL_PRIO    = 3'd2;
    localparam logic [2:0] POL_SJF     = 3'd3;
    localparam logic [2:0] POL_EDF     = 3'd4;

    typedef struct packed {
        logic        kind;
        logic        direction;
        logic [7:0]  job_id;
        logic [7:0]  priority_req;
        logic [15:0] remaining_time;
        logic [15:0] deadline;
    } in_item_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] chosen_id;
        logic       pending;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] rem;
        logic [15:0] dl;
    } job_t;

    // one job of policy comparison: does cand beat best
    function automatic logic job_better(job_t cand, job_t best, logic [2:0] pol);
        logic b;
        b = 1'b0;
        case (pol)
            POL_PRIO: b = cand.prio > best.prio;
            POL_SJF:  b = cand.rem < best.rem;
            POL_EDF:  b = cand.dl < best.dl;
            default:  b = 1'b0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/tqps_front.sv
// ----------------------------------------------------------------------------
// tqps_front
// Input side: takes items into a short command queue for the engine.
// ----------------------------------------------------------------------------
module tqps_front
    import tqps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    output logic     cmd_valid,
    input  logic     cmd_take,
    output in_item_t cmd_item
);

    localparam int PtrW = $clog2(CmdFifoDepth);

    in_item_t              fifo_reg [CmdFifoDepth];
    logic [PtrW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]         cnt_reg, cnt_next;
    logic                  push, pop;

    assign in_stall  = (cnt_reg == (PtrW+1)'(CmdFifoDepth));
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_take && cmd_valid;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_item  = fifo_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_item;
    end

endmodule

FILE: rtl/tqps_engine.sv
// ----------------------------------------------------------------------------
// tqps_engine
// Back end: holds both job queues, scans them one entry a cycle and compacts them.
// ----------------------------------------------------------------------------
module tqps_engine
    import tqps_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [2:0] policy,
    input  logic      cmd_valid,
    output logic      cmd_take,
    input  in_item_t  cmd_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_SHRD  = 7'b0001000,
        ST_SHWR  = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    job_t            mem_l [QUEUE_DEPTH];
    job_t            mem_r [QUEUE_DEPTH];
    job_t            rd_data_reg;
    logic [CntW-1:0] cnt_l_reg, cnt_r_reg, cnt_l_next, cnt_r_next;
    logic            dir_reg;
    logic            deq_reg;
    logic [2:0]      pol_reg;
    logic [IdxW-1:0] idx_reg, idx_next, best_idx_reg, best_idx_next;
    job_t            best_reg, best_next, head_reg, head_next;
    logic [IdxW-1:0] rd_addr;
    logic            rd_en;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    job_t            wr_data;
    logic            out_valid_reg;
    out_item_t       out_reg, out_next;
    logic [CntW-1:0] n_sel, n_sel_next;
    logic            is_rr;
    logic            ld_out;

    assign n_sel = dir_reg ? cnt_r_reg : cnt_l_reg;
    assign is_rr = (pol_reg == POL_RR);

    // control
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        head_next     = head_reg;
        cnt_l_next    = cnt_l_reg;
        cnt_r_next    = cnt_r_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = rd_data_reg;
        cmd_take      = 1'b0;
        ld_out        = 1'b0;
        out_next      = out_reg;
        n_sel_next    = n_sel;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_take = 1'b1;
                    if (cmd_item.kind == KIND_ENQ)
                    begin
                        n_sel_next = cmd_item.direction ? cnt_r_reg : cnt_l_reg;
                        out_next.chosen_id = '0;
                        out_next.ok = (n_sel_next != Full);
                        if (n_sel_next != Full)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = n_sel_next[IdxW-1:0];
                            wr_data = '{cmd_item.job_id, cmd_item.priority_req,
                                        cmd_item.remaining_time, cmd_item.deadline};
                            if (cmd_item.direction)
                                cnt_r_next = cnt_r_reg + 1'b1;
                            else
                                cnt_l_next = cnt_l_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        n_sel_next = cmd_item.direction ? cnt_r_reg : cnt_l_reg;
                        out_next = '0;
                        if (n_sel_next == '0 || policy > POL_EDF)
                            state_next = ST_DONE;
                        else
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = '0;
                            idx_next      = '0;
                            best_idx_next = '0;
                            state_next    = ST_RD;
                        end
                    end
                end
            end
            // head read in flight
            ST_RD:
            begin
                best_next = rd_data_reg;
                head_next = rd_data_reg;
                if (is_rr || pol_reg == POL_FCFS || n_sel == CntW'(1))
                begin
                    idx_next   = '0;
                    state_next = (n_sel == CntW'(1)) ? ST_DONE : ST_SHRD;
                    if (n_sel != CntW'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = IdxW'(1);
                    end
                    else
                        ld_out = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IdxW'(1);
                    idx_next   = IdxW'(1);
                    state_next = ST_SCAN;
                end
            end
            // one compare per cycle
            ST_SCAN:
            begin
                if (job_better(rd_data_reg, best_reg, pol_reg))
                begin
                    best_next     = rd_data_reg;
                    best_idx_next = idx_reg;
                end
                if ((CntW'(idx_reg) + 1'b1) == n_sel)
                begin
                    if (CntW'(best_idx_next) + 1'b1 == n_sel)
                    begin
                        ld_out     = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = best_idx_next;
                        rd_en      = 1'b1;
                        rd_addr    = best_idx_next + 1'b1;
                        state_next = ST_SHRD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            // wait state between the read of entry idx+1 and its write
            ST_SHRD:
            begin
                state_next = ST_SHWR;
            end
            // move entry idx+1 down to idx
            ST_SHWR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
                if ((CntW'(idx_reg) + 2'd2) == n_sel)
                begin
                    ld_out     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg + 2'd2;
                    state_next = ST_SHRD;
                end
            end
            // final write for round robin: old head goes to the tail
            ST_DONE:
            begin
                if (deq_reg && is_rr && out_reg.ok && n_sel != CntW'(1))
                begin
                    wr_en   = 1'b1;
                    wr_addr = IdxW'(n_sel - 1'b1);
                    wr_data = head_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (ld_out)
        begin
            out_next.ok        = 1'b1;
            out_next.chosen_id = (state_reg == ST_RD) ? rd_data_reg.id : best_next.id;
            if (!is_rr)
            begin
                if (dir_reg)
                    cnt_r_next = cnt_r_reg - 1'b1;
                else
                    cnt_l_next = cnt_l_reg - 1'b1;
            end
        end
    end

    // memories, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en && (state_reg == ST_IDLE ? cmd_item.direction : dir_reg))
            mem_r[wr_addr] <= wr_data;
        if (wr_en && !(state_reg == ST_IDLE ? cmd_item.direction : dir_reg))
            mem_l[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= (state_reg == ST_IDLE ? cmd_item.direction : dir_reg)
                           ? mem_r[rd_addr] : mem_l[rd_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        head_reg     <= head_next;
        out_reg      <= out_next;
        if (cmd_take)
        begin
            dir_reg <= cmd_item.direction;
            deq_reg <= (cmd_item.kind == KIND_DEQ);
            pol_reg <= policy;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_l_reg     <= '0;
            cnt_r_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_l_reg <= cnt_l_next;
            cnt_r_reg <= cnt_r_next;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // pending reflects counts after this step
    always_comb
    begin
        out_item         = out_reg;
        out_item.pending = (cnt_l_reg != '0) || (cnt_r_reg != '0);
    end
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/two_queue_policy_scheduler.sv
// ----------------------------------------------------------------------------
// two_queue_policy_scheduler
// Two job queues served by FCFS, round robin, priority, SJF or EDF.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid/in_stall with an in_item_t payload; each
// item yields one out_item_t transfer on out_valid/out_stall. The user must
// write the policy register through policy_we/policy_wdata only while the
// block is idle; the block itself does not enforce this. An input item lands
// in a two-entry command queue, so the input side keeps taking items, until
// the queue is full, while the engine works or its result waits. An enqueue
// writes its job as it is taken. A dequeue reads the queue through a
// registered memory port, one entry a cycle in a selection scan over N stored
// jobs; the compaction of the entries behind the chosen job takes a read
// and a write state per entry. One item is in the engine at a time.
// Reset empties both queues and sets the policy to FCFS; queue contents are
// not cleared. While out_stall is high the result holds and the engine
// waits; the command queue still takes up to two items.
module two_queue_policy_scheduler
    import tqps_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       policy_we,
    input  logic [2:0] policy_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    logic [2:0] policy_reg;
    logic       cmd_valid, cmd_take;
    in_item_t   cmd_item;

    // policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= POL_FCFS;
        else if (policy_we)
            policy_reg <= policy_wdata;
    end

    tqps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_item  (cmd_item)
    );

    tqps_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .policy    (policy_reg),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_item  (cmd_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // a failed transfer never carries an id
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.ok) |-> (out_item.chosen_id == '0))
        else $error("failed result carries an id");

    // a stalled result holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");

    // engine takes a command only with no result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> !out_valid)
        else $error("command taken while result waits");

endmodule
